@@ rtl/shsh_pkg.sv @@
`default_nettype none
package shsh_pkg;

    // Input modes.
    localparam logic [1:0] MODE_ABSORB  = 2'd0;
    localparam logic [1:0] MODE_DIGEST  = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    // Position at which the length field begins in a padded block.
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [63:0] digest_top;
        logic [63:0] digest_upper_mid;
        logic [63:0] digest_lower_mid;
        logic [63:0] digest_bottom;
    } t_out_word;

    // Where the bytes of a block come from.
    typedef enum logic [1:0] {
        SRC_BUFFER,
        SRC_PAD_FIRST,
        SRC_PAD_SECOND
    } t_src;

    // Command from the controller to the compression core.
    typedef struct packed {
        logic start;
        logic chain;   // Take the previous sum as the base instead of i_base.
        t_src src;
    } t_core_cmd;

    function automatic logic [31:0] big0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    // Round constants.
    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

@@ rtl/sha256_stream_hasher_unit.sv @@
`default_nettype none
// An absorb word is written into the block buffer; the word that completes a block
// also starts the compression core. A digest pads one block, or two when the padding
// spills past the length field. One word at a time: input stalls while the compression
// core (byte loads from the block buffer, 64 rounds and one finishing step) runs.
// Reset (synchronous, active low) loads the initial hash and clears length and fill.
module sha256_stream_hasher_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire shsh_pkg::t_in_word  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output shsh_pkg::t_out_word      o_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_DIG_A,
        ST_DIG_B,
        ST_DIG_OUT
    } t_state;

    t_state              r_state;
    logic [255:0]        r_cv;
    logic [5:0]          r_fill;
    logic [63:0]         r_bit_len;
    logic                r_ovld;
    shsh_pkg::t_out_word r_out;

    shsh_pkg::t_core_cmd core_cmd;
    logic [5:0]          raddr;
    logic [7:0]          rdata;
    logic                core_done;
    logic [255:0]        core_sum;
    logic                accept;
    logic                buf_we;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign buf_we      = accept && (i_in.mode == shsh_pkg::MODE_ABSORB);
    assign o_out_valid = r_ovld;
    assign o_out       = r_out;

    // Commands to the core.
    always_comb begin
        core_cmd.start = 1'b0;
        core_cmd.chain = 1'b0;
        core_cmd.src   = shsh_pkg::SRC_BUFFER;
        if (buf_we && r_fill == 6'd63) begin
            core_cmd.start = 1'b1;
        end else if (accept && i_in.mode == shsh_pkg::MODE_DIGEST) begin
            core_cmd.start = 1'b1;
            core_cmd.src   = shsh_pkg::SRC_PAD_FIRST;
        end else if (r_state == ST_DIG_A && core_done && r_fill >= shsh_pkg::LEN_POS) begin
            core_cmd.start = 1'b1;
            core_cmd.chain = 1'b1;
            core_cmd.src   = shsh_pkg::SRC_PAD_SECOND;
        end
    end

    shsh_buf u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_fill),
        .i_wdata (i_in.data_byte),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    shsh_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (core_cmd),
        .i_base    (r_cv),
        .i_fill    (r_fill),
        .i_bit_len (r_bit_len),
        .o_raddr   (raddr),
        .i_rdata   (rdata),
        .o_done    (core_done),
        .o_sum     (core_sum)
    );

    // Control, hash state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cv      <= shsh_pkg::INIT_HASH;
            r_fill    <= 6'd0;
            r_bit_len <= 64'd0;
            r_ovld    <= 1'b0;
        end else begin
            if (r_ovld && !i_out_stall && r_state != ST_DIG_OUT) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (i_in.mode)
                            shsh_pkg::MODE_ABSORB: begin
                                r_fill    <= r_fill + 6'd1;
                                r_bit_len <= r_bit_len + 64'd8;
                                if (r_fill == 6'd63) begin
                                    r_state <= ST_ABSORB;
                                end
                            end
                            shsh_pkg::MODE_DIGEST: begin
                                r_state <= ST_DIG_A;
                            end
                            shsh_pkg::MODE_RESTART: begin
                                r_cv      <= shsh_pkg::INIT_HASH;
                                r_fill    <= 6'd0;
                                r_bit_len <= 64'd0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_ABSORB: begin
                    if (core_done) begin
                        r_cv    <= core_sum;
                        r_state <= ST_IDLE;
                    end
                end
                ST_DIG_A: begin
                    if (core_done) begin
                        r_state <= (r_fill >= shsh_pkg::LEN_POS) ? ST_DIG_B : ST_DIG_OUT;
                    end
                end
                ST_DIG_B: begin
                    if (core_done) begin
                        r_state <= ST_DIG_OUT;
                    end
                end
                ST_DIG_OUT: begin
                    if (!r_ovld || !i_out_stall) begin
                        r_out   <= core_sum;
                        r_ovld  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/shsh_buf.sv @@
`default_nettype none
// Block buffer: 64 bytes, one write port and one registered read port.
module shsh_buf (
    input  wire logic       i_clk,
    input  wire logic       i_we,
    input  wire logic [5:0] i_waddr,
    input  wire logic [7:0] i_wdata,
    input  wire logic [5:0] i_raddr,
    output logic      [7:0] o_rdata
);

    logic [7:0] r_mem [64];
    logic [7:0] r_rdata;

    // Write, and read through the output register.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/shsh_core.sv @@
`default_nettype none
// Compression core: streams 64 bytes out of the buffer into the schedule line,
// then runs one round a cycle.
module shsh_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire shsh_pkg::t_core_cmd i_cmd,
    input  wire logic [255:0]        i_base,
    input  wire logic [5:0]          i_fill,
    input  wire logic [63:0]         i_bit_len,
    output logic      [5:0]          o_raddr,
    input  wire logic [7:0]          i_rdata,
    output logic                     o_done,
    output logic      [255:0]        o_sum
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } t_state;

    t_state              r_state;
    shsh_pkg::t_src      r_src;
    logic [6:0]          r_cnt;
    logic                r_rdv;
    logic [5:0]          r_bidx;
    logic [5:0]          r_rnd;
    logic [511:0]        r_wline;
    logic [31:0]         r_hb [8];
    logic [31:0]         r_v [8];

    logic [7:0]          byte_in;
    logic [63:0]         len_sh;
    logic [31:0]         w16;
    logic [31:0]         t1;
    logic [31:0]         t2;
    logic [31:0]         ch;
    logic [31:0]         maj;

    assign o_raddr = r_cnt[5:0];
    assign o_done  = (r_state == ST_DONE);

    // Sum of base and working variables.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_sum[255 - 32*i -: 32] = r_hb[i] + r_v[i];
        end
    end

    // Byte of the block at position r_bidx, padded as the source asks.
    always_comb begin
        len_sh = i_bit_len >> {~r_bidx[2:0], 3'b000};
        case (r_src)
            shsh_pkg::SRC_BUFFER: begin
                byte_in = i_rdata;
            end
            shsh_pkg::SRC_PAD_FIRST: begin
                if (r_bidx < i_fill) begin
                    byte_in = i_rdata;
                end else if (r_bidx == i_fill) begin
                    byte_in = shsh_pkg::PAD_BYTE;
                end else if (i_fill < shsh_pkg::LEN_POS && r_bidx >= shsh_pkg::LEN_POS) begin
                    byte_in = len_sh[7:0];
                end else begin
                    byte_in = 8'h00;
                end
            end
            shsh_pkg::SRC_PAD_SECOND: begin
                byte_in = (r_bidx >= shsh_pkg::LEN_POS) ? len_sh[7:0] : 8'h00;
            end
            default: begin
                byte_in = 8'h00;
            end
        endcase
    end

    // Round and schedule arithmetic.
    always_comb begin
        w16 = r_wline[511:480] + shsh_pkg::sig0(r_wline[479:448])
            + r_wline[223:192] + shsh_pkg::sig1(r_wline[63:32]);
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1  = r_v[7] + shsh_pkg::big1(r_v[4]) + ch + shsh_pkg::round_k(r_rnd)
            + r_wline[511:480];
        t2  = shsh_pkg::big0(r_v[0]) + maj;
    end

    // Sequencer and datapath registers. A new block may start straight from
    // the finishing cycle, so that a chained second block is not missed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 7'd0;
            r_rdv   <= 1'b0;
            r_rnd   <= 6'd0;
        end else begin
            case (r_state)
                ST_IDLE, ST_DONE: begin
                    if (i_cmd.start) begin
                        r_src   <= i_cmd.src;
                        r_cnt   <= 7'd0;
                        r_rdv   <= 1'b0;
                        r_state <= ST_LOAD;
                        for (int i = 0; i < 8; i++) begin
                            r_hb[i] <= i_cmd.chain ? o_sum[255 - 32*i -: 32]
                                                   : i_base[255 - 32*i -: 32];
                        end
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_LOAD: begin
                    r_rdv  <= ~r_cnt[6];
                    r_bidx <= r_cnt[5:0];
                    if (r_rdv) begin
                        r_wline <= {r_wline[503:0], byte_in};
                    end
                    if (r_cnt[6]) begin
                        r_state <= ST_ROUND;
                        r_rnd   <= 6'd0;
                        for (int i = 0; i < 8; i++) begin
                            r_v[i] <= r_hb[i];
                        end
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                ST_ROUND: begin
                    r_v[7]  <= r_v[6];
                    r_v[6]  <= r_v[5];
                    r_v[5]  <= r_v[4];
                    r_v[4]  <= r_v[3] + t1;
                    r_v[3]  <= r_v[2];
                    r_v[2]  <= r_v[1];
                    r_v[1]  <= r_v[0];
                    r_v[0]  <= t1 + t2;
                    r_wline <= {r_wline[479:0], w16};
                    r_rnd   <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) begin
                        r_state <= ST_DONE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ test/tb_sha256_stream_hasher_unit.sv @@
module tb_sha256_stream_hasher_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Mode code that the block ignores.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Digest predictor and store of digests still owed by the block.
    class digest_board;
        logic [31:0]         chain_h[8];
        logic [7:0]          buf_b[64];
        logic [5:0]          fill;
        logic [63:0]         nbits;
        shsh_pkg::t_out_word owed[$];
        int                  errors;

        function void clear_hash();
            for (int i = 0; i < 8; i++) chain_h[i] = shsh_pkg::INIT_HASH[255 - 32*i -: 32];
            for (int i = 0; i < 64; i++) buf_b[i] = 8'h00;
            fill = 6'd0;
            nbits = 64'd0;
        endfunction

        function void compress(ref logic [31:0] h[8], input logic [7:0] blk[64]);
            logic [31:0] w[64];
            logic [31:0] v[8];
            logic [31:0] t1, t2, ch, mj;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 64; i++) begin
                t1 = {w[i-15][6:0], w[i-15][31:7]} ^ {w[i-15][17:0], w[i-15][31:18]}
                     ^ (w[i-15] >> 3);
                t2 = {w[i-2][16:0], w[i-2][31:17]} ^ {w[i-2][18:0], w[i-2][31:19]}
                     ^ (w[i-2] >> 10);
                w[i] = w[i-16] + t1 + w[i-7] + t2;
            end
            for (int i = 0; i < 8; i++) v[i] = h[i];
            for (int i = 0; i < 64; i++) begin
                ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
                mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
                t1 = v[7] + ({v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]}
                     ^ {v[4][24:0], v[4][31:25]}) + ch + shsh_pkg::round_k(i[5:0]) + w[i];
                t2 = ({v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]}
                     ^ {v[0][21:0], v[0][31:22]}) + mj;
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) h[i] += v[i];
        endfunction

        // Notes an accepted input word and predicts its digest, if any.
        function void note_input(shsh_pkg::t_in_word wd);
            logic [7:0]          blk[64];
            logic [31:0]         h[8];
            int                  pos;
            shsh_pkg::t_out_word d;
            case (wd.mode)
                shsh_pkg::MODE_ABSORB: begin
                    buf_b[fill] = wd.data_byte;
                    fill++;
                    nbits += 64'd8;
                    if (fill == 6'd0) compress(chain_h, buf_b);
                end
                shsh_pkg::MODE_RESTART: clear_hash();
                shsh_pkg::MODE_DIGEST: begin
                    blk = buf_b;
                    h = chain_h;
                    pos = fill;
                    blk[pos] = shsh_pkg::PAD_BYTE;
                    pos++;
                    if (pos > shsh_pkg::LEN_POS) begin
                        while (pos < 64) blk[pos++] = 8'h00;
                        compress(h, blk);
                        pos = 0;
                    end
                    while (pos < shsh_pkg::LEN_POS) blk[pos++] = 8'h00;
                    for (int i = 0; i < 8; i++) blk[56+i] = nbits[63 - 8*i -: 8];
                    compress(h, blk);
                    d = {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
                    owed.push_back(d);
                end
                default: ;
            endcase
        endfunction

        // Compares an accepted digest with the oldest one owed.
        function void check_digest(shsh_pkg::t_out_word got);
            shsh_pkg::t_out_word exp_d;
            if (owed.size() == 0) begin
                $display("%0t: unexpected digest %h", $realtime, got);
                errors++;
                return;
            end
            exp_d = owed.pop_front();
            if (got.digest_top !== exp_d.digest_top)
                $display("%0t: digest_top exp %h got %h", $realtime,
                         exp_d.digest_top, got.digest_top);
            if (got.digest_upper_mid !== exp_d.digest_upper_mid)
                $display("%0t: digest_upper_mid exp %h got %h", $realtime,
                         exp_d.digest_upper_mid, got.digest_upper_mid);
            if (got.digest_lower_mid !== exp_d.digest_lower_mid)
                $display("%0t: digest_lower_mid exp %h got %h", $realtime,
                         exp_d.digest_lower_mid, got.digest_lower_mid);
            if (got.digest_bottom !== exp_d.digest_bottom)
                $display("%0t: digest_bottom exp %h got %h", $realtime,
                         exp_d.digest_bottom, got.digest_bottom);
            if (got !== exp_d) errors++;
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    shsh_pkg::t_in_word  i_in;
    logic                o_out_valid;
    logic                i_out_stall;
    shsh_pkg::t_out_word o_out;

    digest_board board;
    int          word_count;
    bit          calm;

    sha256_stream_hasher_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drives one word and holds it until the block takes it.
    task automatic send_word(input logic [1:0] mode, input logic [7:0] data);
        while (!calm && $urandom_range(99) < 24) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= '{mode: mode, data_byte: data};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_input('{mode: mode, data_byte: data});
        word_count++;
    endtask

    task automatic absorb_run(input int n);
        for (int i = 0; i < n; i++) send_word(shsh_pkg::MODE_ABSORB, 8'($urandom));
    endtask

    // Receiving side: random stall, checks every accepted digest.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_digest(o_out);
        i_out_stall <= !calm && ($urandom_range(99) < 24);
    end

    initial begin
        int kind;
        board = new();
        board.clear_hash();
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, byte extremes, pad spill, restart, unused mode.
        send_word(shsh_pkg::MODE_DIGEST, 8'hff);
        send_word(shsh_pkg::MODE_ABSORB, 8'h00);
        send_word(shsh_pkg::MODE_ABSORB, 8'hff);
        send_word(shsh_pkg::MODE_DIGEST, 8'h00);
        send_word(MODE_SPARE, 8'hff);
        send_word(shsh_pkg::MODE_DIGEST, 8'h00);
        send_word(shsh_pkg::MODE_RESTART, 8'h55);
        absorb_run(55);
        send_word(shsh_pkg::MODE_DIGEST, 8'h00);
        send_word(shsh_pkg::MODE_ABSORB, 8'haa);
        send_word(shsh_pkg::MODE_DIGEST, 8'h00);
        absorb_run(8);
        send_word(shsh_pkg::MODE_DIGEST, 8'h00);
        send_word(shsh_pkg::MODE_RESTART, 8'h00);

        // Random: mostly byte streams with digests at random points.
        while (word_count < 1650) begin
            calm = (word_count >= 700 && word_count < 900);
            kind = $urandom_range(99);
            if (kind < 80) send_word(shsh_pkg::MODE_ABSORB, 8'($urandom));
            else if (kind < 93) send_word(shsh_pkg::MODE_DIGEST, 8'($urandom));
            else if (kind < 97) send_word(shsh_pkg::MODE_RESTART, 8'($urandom));
            else send_word(MODE_SPARE, 8'($urandom));
        end
        i_in_valid <= 1'b0;
        calm = 1'b0;

        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (board.errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
